>>> src/ahc_pkg.sv
`default_nettype none

package ahc_pkg;

    localparam int ALT_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;
    localparam int GAIN_W    = 12;
    localparam int THR_W     = 11;
    localparam int ADJ_W     = 10;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = GAIN_W + 1 + MUL_B_W;

    localparam int ERR_LIM      = 500;
    localparam int DEADBAND     = 10;
    localparam int SETV_LIM     = 300;
    localparam int PTERM_LIM    = 300;
    localparam int DTERM_LIM    = 150;
    localparam int TILT_LIM     = 800;
    localparam int CENTRE_LO    = 1460;
    localparam int CENTRE_HI    = 1540;
    localparam int STICK_BAND   = 40;
    localparam int STICK_STEP   = 40;
    localparam int STICK_MID    = 1000;
    localparam int THR_MIN      = 1000;
    localparam int THR_MAX      = 2000;
    localparam int HOLD_REF_RST = 1500;
    localparam int BASE_RST     = 1500;
    localparam int GAIN_ONE     = 256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FAST_MODE   = 3'd0,
        REG_STICK_REF   = 3'd1,
        REG_BASE_THR    = 3'd2,
        REG_ALT_GAIN    = 3'd3,
        REG_VEL_GAIN    = 3'd4,
        REG_DAMP_GAIN   = 3'd5
    } ahc_reg_idx_t;

    typedef enum logic [1:0] {
        MUL_ALT  = 2'd0,
        MUL_VEL  = 2'd1,
        MUL_DAMP = 2'd2
    } ahc_mul_sel_t;

    typedef struct packed {
        logic         load;
        logic         err_step;
        logic         mul_en;
        ahc_mul_sel_t mul_sel;
        logic         setv_step;
        logic         p_step;
        logic         fin;
    } ahc_cmd_t;

    typedef struct packed {
        logic out_stall;
    } ahc_status_t;

endpackage

`default_nettype wire

>>> src/ahc_ctrl.sv
`default_nettype none

module ahc_ctrl import ahc_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire ahc_status_t status,
    output ahc_cmd_t   cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ERR   = 7'b0000010,
        ST_MALT  = 7'b0000100,
        ST_SETV  = 7'b0001000,
        ST_MVEL  = 7'b0010000,
        ST_MDAMP = 7'b0100000,
        ST_FIN   = 7'b1000000
    } ahc_state_t;

    ahc_state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_ALT;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                cmd.err_step = 1'b1;
                state_next   = ST_MALT;
            end
            ST_MALT: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ALT;
                state_next  = ST_SETV;
            end
            ST_SETV: begin
                cmd.setv_step = 1'b1;
                state_next    = ST_MVEL;
            end
            ST_MVEL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_VEL;
                state_next  = ST_MDAMP;
            end
            ST_MDAMP: begin
                // velocity term is clamped while the damping product forms
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DAMP;
                cmd.p_step  = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                if (!status.out_stall) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> src/ahc_datapath.sv
`default_nettype none

module ahc_datapath import ahc_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire ahc_cmd_t               cmd,
    output ahc_status_t                 status,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DAT_W-1:0]   cfg_data,
    input  wire logic [THR_W-1:0]       s_stick_throttle,
    input  wire logic signed [ALT_W-1:0] s_estimated_altitude,
    input  wire logic signed [11:0]     s_vertical_velocity,
    input  wire logic signed [15:0]     s_vertical_accel,
    input  wire logic signed [11:0]     s_pitch_angle,
    input  wire logic signed [11:0]     s_roll_angle,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic signed [ADJ_W-1:0]     m_throttle_adjustment,
    output logic [THR_W-1:0]            m_motor_throttle,
    output logic                        m_velocity_mode
);

    // configuration
    logic              fast_mode_reg;
    logic [THR_W-1:0]  stick_ref_reg;
    logic [THR_W-1:0]  base_thr_reg;
    logic [GAIN_W-1:0] alt_gain_reg;
    logic [GAIN_W-1:0] vel_gain_reg;
    logic [GAIN_W-1:0] damp_gain_reg;

    // controller state
    logic signed [ALT_W-1:0] hold_alt_reg, hold_alt_next;
    logic                    vel_ctrl_reg, vel_ctrl_next;
    logic                    moved_reg, moved_next;
    logic signed [THR_W-1:0] cmd_vel_reg, cmd_vel_next;
    logic [THR_W-1:0]        last_thr_reg, last_thr_next;
    logic signed [15:0]      prev_acc_reg;

    // working registers
    logic [THR_W-1:0]        stick_reg;
    logic signed [ALT_W-1:0] est_reg;
    logic signed [11:0]      vel_reg;
    logic signed [15:0]      acc_reg;
    logic                    upright_reg;
    logic signed [ADJ_W-1:0] err_reg;
    logic signed [16:0]      acc_sum_reg;
    logic signed [12:0]      verr_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ADJ_W-1:0] p_reg;

    logic                    m_valid_reg;
    logic signed [ADJ_W-1:0] m_adj_reg;
    logic [THR_W-1:0]        m_thr_reg;
    logic                    m_vmode_reg;

    assign status.out_stall     = m_valid_reg & ~m_ready;
    assign m_valid              = m_valid_reg;
    assign m_throttle_adjustment = m_adj_reg;
    assign m_motor_throttle     = m_thr_reg;
    assign m_velocity_mode      = m_vmode_reg;

    // ---------------- altitude error ----------------
    logic                    centred;
    logic signed [ALT_W-1:0] hold_eff;
    logic signed [ALT_W:0]   alt_diff;
    logic signed [ADJ_W-1:0] err_cl, err_db;

    assign centred  = (stick_reg > THR_W'(CENTRE_LO)) && (stick_reg < THR_W'(CENTRE_HI));
    assign hold_eff = (upright_reg && centred) ? est_reg : hold_alt_reg;
    assign alt_diff = $signed({hold_eff[ALT_W-1], hold_eff}) - $signed({est_reg[ALT_W-1], est_reg});

    always_comb begin
        if (alt_diff > ERR_LIM) begin
            err_cl = ADJ_W'(ERR_LIM);
        end else if (alt_diff < -ERR_LIM) begin
            err_cl = ADJ_W'(-ERR_LIM);
        end else begin
            err_cl = alt_diff[ADJ_W-1:0];
        end
        if ((err_cl < DEADBAND) && (err_cl > -DEADBAND)) begin
            err_db = '0;
        end else if (err_cl > 0) begin
            err_db = err_cl - ADJ_W'(DEADBAND);
        end else begin
            err_db = err_cl + ADJ_W'(DEADBAND);
        end
    end

    // ---------------- shared multiplier ----------------
    logic [GAIN_W-1:0]        mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_next;

    always_comb begin
        unique case (cmd.mul_sel)
            MUL_ALT: begin
                mul_a = alt_gain_reg;
                mul_b = MUL_B_W'(err_reg);
            end
            MUL_VEL: begin
                mul_a = vel_gain_reg;
                mul_b = MUL_B_W'(verr_reg);
            end
            MUL_DAMP: begin
                mul_a = damp_gain_reg;
                mul_b = acc_sum_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'($signed({1'b0, mul_a})) * PROD_W'(mul_b);

    // ---------------- clamps on the product (floor by arithmetic shift) ----------------
    logic signed [PROD_W-9:0]  prod_q8;
    logic signed [PROD_W-17:0] prod_q16;
    logic signed [ADJ_W-1:0]   q8_cl, d_cl, setv;
    logic signed [12:0]        verr_next;

    assign prod_q8  = prod_reg[PROD_W-1:8];
    assign prod_q16 = prod_reg[PROD_W-1:16];

    always_comb begin
        if (prod_q8 > SETV_LIM) begin
            q8_cl = ADJ_W'(SETV_LIM);
        end else if (prod_q8 < -SETV_LIM) begin
            q8_cl = ADJ_W'(-SETV_LIM);
        end else begin
            q8_cl = prod_q8[ADJ_W-1:0];
        end
        if (prod_q16 > DTERM_LIM) begin
            d_cl = ADJ_W'(DTERM_LIM);
        end else if (prod_q16 < -DTERM_LIM) begin
            d_cl = ADJ_W'(-DTERM_LIM);
        end else begin
            d_cl = prod_q16[ADJ_W-1:0];
        end
    end

    assign setv      = q8_cl;
    // velocity setpoint: stick command when in velocity mode, else altitude loop
    assign verr_next = (vel_ctrl_reg ? 13'(cmd_vel_reg) : 13'(setv)) - 13'(vel_reg);

    // ---------------- final step: adjustment and stick handling ----------------
    logic signed [ADJ_W:0]   adj_raw;
    logic signed [ADJ_W-1:0] adj;
    logic signed [11:0]      diff;
    logic signed [11:0]      diff_half;
    logic                    stick_out;
    logic signed [12:0]      step_sum, base_sum;
    logic [THR_W-1:0]        step_thr, base_thr_sat;

    assign adj_raw   = $signed({p_reg[ADJ_W-1], p_reg}) - $signed({d_cl[ADJ_W-1], d_cl});
    assign adj       = upright_reg ? adj_raw[ADJ_W-1:0] : '0;
    assign diff      = $signed({1'b0, stick_reg}) - $signed({1'b0, stick_ref_reg});
    assign stick_out = (diff > STICK_BAND) || (diff < -STICK_BAND);
    // halve, truncating toward zero
    assign diff_half = (diff + (diff < 0 ? 12'sd1 : 12'sd0)) >>> 1;
    assign step_sum  = $signed({2'b0, last_thr_reg}) +
                       ((stick_reg > THR_W'(STICK_MID)) ? 13'(-STICK_STEP) : 13'(STICK_STEP));
    assign base_sum  = $signed({2'b0, base_thr_reg}) + 13'(adj);

    always_comb begin
        if (step_sum > THR_MAX) begin
            step_thr = THR_W'(THR_MAX);
        end else if (step_sum < THR_MIN) begin
            step_thr = THR_W'(THR_MIN);
        end else begin
            step_thr = step_sum[THR_W-1:0];
        end
        if (base_sum > THR_MAX) begin
            base_thr_sat = THR_W'(THR_MAX);
        end else if (base_sum < THR_MIN) begin
            base_thr_sat = THR_W'(THR_MIN);
        end else begin
            base_thr_sat = base_sum[THR_W-1:0];
        end
    end

    always_comb begin
        hold_alt_next = hold_alt_reg;
        vel_ctrl_next = vel_ctrl_reg;
        moved_next    = moved_reg;
        cmd_vel_next  = cmd_vel_reg;
        last_thr_next = last_thr_reg;
        if (cmd.err_step && upright_reg && centred) begin
            hold_alt_next = est_reg;
        end
        if (cmd.fin) begin
            if (fast_mode_reg) begin
                if (stick_out) begin
                    moved_next    = 1'b1;
                    last_thr_next = step_thr;
                end else begin
                    if (moved_reg) begin
                        hold_alt_next = est_reg;
                        moved_next    = 1'b0;
                    end
                    last_thr_next = base_thr_sat;
                end
            end else begin
                if (stick_out) begin
                    cmd_vel_next  = diff_half[THR_W-1:0];
                    vel_ctrl_next = 1'b1;
                    moved_next    = 1'b1;
                end else if (moved_reg) begin
                    hold_alt_next = est_reg;
                    vel_ctrl_next = 1'b0;
                    moved_next    = 1'b0;
                end
                last_thr_next = base_thr_sat;
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_mode_reg <= 1'b0;
            stick_ref_reg <= THR_W'(HOLD_REF_RST);
            base_thr_reg  <= THR_W'(BASE_RST);
            alt_gain_reg  <= GAIN_W'(GAIN_ONE);
            vel_gain_reg  <= GAIN_W'(GAIN_ONE);
            damp_gain_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FAST_MODE: fast_mode_reg <= cfg_data[0];
                REG_STICK_REF: stick_ref_reg <= cfg_data[THR_W-1:0];
                REG_BASE_THR:  base_thr_reg  <= cfg_data[THR_W-1:0];
                REG_ALT_GAIN:  alt_gain_reg  <= cfg_data;
                REG_VEL_GAIN:  vel_gain_reg  <= cfg_data;
                REG_DAMP_GAIN: damp_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_alt_reg <= '0;
            vel_ctrl_reg <= 1'b0;
            moved_reg    <= 1'b0;
            cmd_vel_reg  <= '0;
            last_thr_reg <= THR_W'(THR_MIN);
            prev_acc_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            hold_alt_reg <= hold_alt_next;
            vel_ctrl_reg <= vel_ctrl_next;
            moved_reg    <= moved_next;
            cmd_vel_reg  <= cmd_vel_next;
            last_thr_reg <= last_thr_next;
            if (cmd.err_step) begin
                prev_acc_reg <= acc_reg;
            end
            if (cmd.fin) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            stick_reg   <= s_stick_throttle;
            est_reg     <= s_estimated_altitude;
            vel_reg     <= s_vertical_velocity;
            acc_reg     <= s_vertical_accel;
            upright_reg <= (s_pitch_angle < TILT_LIM) && (s_pitch_angle > -TILT_LIM) &&
                           (s_roll_angle < TILT_LIM) && (s_roll_angle > -TILT_LIM);
        end
        if (cmd.err_step) begin
            err_reg     <= err_db;
            acc_sum_reg <= 17'(acc_reg) + 17'(prev_acc_reg);
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.setv_step) begin
            verr_reg <= verr_next;
        end
        if (cmd.p_step) begin
            p_reg <= q8_cl;
        end
        if (cmd.fin) begin
            m_adj_reg   <= adj;
            m_thr_reg   <= last_thr_next;
            m_vmode_reg <= vel_ctrl_next;
        end
    end

endmodule

`default_nettype wire

>>> src/altitude_hold_controller.sv
// Each input transfer walks the sequencer through ERR, MALT, SETV, MVEL,
// MDAMP and FIN, then the result is presented; new input waits for IDLE.
// One shared 13x17 multiplier forms altitude, velocity and damping products.
// A pending result holds the final step until it is taken.
// Reset: synchronous, active low aresetn; registers return to defaults and
// controller state (hold altitude, modes, last throttle 1000) clears.
`default_nettype none

module altitude_hold_controller import ahc_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DAT_W-1:0]    cfg_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [THR_W-1:0]        s_stick_throttle,
    input  wire logic signed [ALT_W-1:0] s_estimated_altitude,
    input  wire logic signed [11:0]      s_vertical_velocity,
    input  wire logic signed [15:0]      s_vertical_accel,
    input  wire logic signed [11:0]      s_pitch_angle,
    input  wire logic signed [11:0]      s_roll_angle,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [ADJ_W-1:0]      m_throttle_adjustment,
    output logic [THR_W-1:0]             m_motor_throttle,
    output logic                         m_velocity_mode
);

    ahc_cmd_t    cmd;
    ahc_status_t status;

    assign cfg_ready = 1'b1;

    ahc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ahc_datapath u_datapath (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .status                (status),
        .cfg_valid             (cfg_valid),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .s_stick_throttle      (s_stick_throttle),
        .s_estimated_altitude  (s_estimated_altitude),
        .s_vertical_velocity   (s_vertical_velocity),
        .s_vertical_accel      (s_vertical_accel),
        .s_pitch_angle         (s_pitch_angle),
        .s_roll_angle          (s_roll_angle),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_throttle_adjustment (m_throttle_adjustment),
        .m_motor_throttle      (m_motor_throttle),
        .m_velocity_mode       (m_velocity_mode)
    );

endmodule

`default_nettype wire

>>> tb/sv/altitude_hold_controller_tb.sv
`timescale 1ns / 100ps

module altitude_hold_controller_tb;
    import ahc_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 3;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 240;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int STICK_MAX      = (1 << THR_W) - 1;
    localparam int GAIN_MAX       = (1 << GAIN_W) - 1;
    localparam int ALT_MAX        = (1 << (ALT_W - 1)) - 1;
    localparam int ALT_MIN        = -(1 << (ALT_W - 1));
    localparam int ANGLE_MAX      = 2047;
    localparam int ANGLE_MIN      = -2048;
    localparam int VEL_MAX        = 2047;
    localparam int VEL_MIN        = -2048;
    localparam int ACC_MAX        = 32767;
    localparam int ACC_MIN        = -32768;

    // indexes outside the register map, writes to these must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(int'(REG_DAMP_GAIN) + 1);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [THR_W-1:0]        stick;
        logic signed [ALT_W-1:0] altitude;
        logic signed [11:0]      velocity;
        logic signed [15:0]      accel;
        logic signed [11:0]      pitch;
        logic signed [11:0]      roll;
    } tick_t;

    typedef struct packed {
        logic signed [ADJ_W-1:0] adjust;
        logic [THR_W-1:0]        motor;
        logic                    vmode;
    } thr_cmd_t;

    typedef struct packed {
        logic              fast;
        logic [THR_W-1:0]  hold_ref;
        logic [THR_W-1:0]  base;
        logic [GAIN_W-1:0] alt_gain;
        logic [GAIN_W-1:0] vel_gain;
        logic [GAIN_W-1:0] damp_gain;
    } cfg_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DAT_W-1:0]    cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [THR_W-1:0]        s_stick_throttle;
    logic signed [ALT_W-1:0] s_estimated_altitude;
    logic signed [11:0]      s_vertical_velocity;
    logic signed [15:0]      s_vertical_accel;
    logic signed [11:0]      s_pitch_angle;
    logic signed [11:0]      s_roll_angle;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [ADJ_W-1:0] m_throttle_adjustment;
    logic [THR_W-1:0]        m_motor_throttle;
    logic                    m_velocity_mode;

    // predictor copy of the registers
    logic              set_fast;
    logic [THR_W-1:0]  set_hold_ref;
    logic [THR_W-1:0]  set_base_thr;
    logic [GAIN_W-1:0] set_alt_gain;
    logic [GAIN_W-1:0] set_vel_gain;
    logic [GAIN_W-1:0] set_damp_gain;

    // predictor copy of the controller state
    logic signed [ALT_W-1:0] trk_hold_alt;
    logic                    trk_vel_mode;
    logic                    trk_stick_moved;
    logic signed [THR_W-1:0] trk_cmd_vel;
    logic [THR_W-1:0]        trk_last_thr;
    logic signed [15:0]      trk_prev_accel;

    thr_cmd_t expected_cmds[$];

    int errors           = 0;
    int ticks_sent       = 0;
    int cmds_checked     = 0;
    int settings_applied = 0;
    int send_idle_pct    = 0;
    int recv_stall_pct   = 0;
    int quiet_cycles     = 0;
    int alt_walk         = 0;

    altitude_hold_controller i_dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_stick_throttle      (s_stick_throttle),
        .s_estimated_altitude  (s_estimated_altitude),
        .s_vertical_velocity   (s_vertical_velocity),
        .s_vertical_accel      (s_vertical_accel),
        .s_pitch_angle         (s_pitch_angle),
        .s_roll_angle          (s_roll_angle),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_throttle_adjustment (m_throttle_adjustment),
        .m_motor_throttle      (m_motor_throttle),
        .m_velocity_mode       (m_velocity_mode)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic int clip(input int x, input int lo, input int hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic int iabs(input int x);
        return (x < 0) ? -x : x;
    endfunction

    // division rounding towards minus infinity
    function automatic int floor_div(input int x, input int d);
        int q;
        q = x / d;
        if ((x % d) != 0 && x < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic int rnd(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    task automatic reset_tracker();
        set_fast        = 1'b0;
        set_hold_ref    = THR_W'(HOLD_REF_RST);
        set_base_thr    = THR_W'(BASE_RST);
        set_alt_gain    = GAIN_W'(GAIN_ONE);
        set_vel_gain    = GAIN_W'(GAIN_ONE);
        set_damp_gain   = '0;
        trk_hold_alt    = '0;
        trk_vel_mode    = 1'b0;
        trk_stick_moved = 1'b0;
        trk_cmd_vel     = '0;
        trk_last_thr    = THR_W'(THR_MIN);
        trk_prev_accel  = '0;
    endtask

    function automatic thr_cmd_t predict_throttle(input tick_t t);
        int stick, alt, vel, acc, pitch, roll;
        int err, setvel, pterm, dterm, adj, diff;
        thr_cmd_t r;
        stick = int'(t.stick);
        alt   = int'(t.altitude);
        vel   = int'(t.velocity);
        acc   = int'(t.accel);
        pitch = int'(t.pitch);
        roll  = int'(t.roll);
        adj   = 0;
        if (iabs(pitch) < TILT_LIM && iabs(roll) < TILT_LIM) begin
            if (stick > CENTRE_LO && stick < CENTRE_HI)
                trk_hold_alt = t.altitude;
            if (!trk_vel_mode) begin
                err = clip(int'(trk_hold_alt) - alt, -ERR_LIM, ERR_LIM);
                if (iabs(err) < DEADBAND)
                    err = 0;
                else if (err > 0)
                    err = err - DEADBAND;
                else
                    err = err + DEADBAND;
                setvel = clip(floor_div(int'(set_alt_gain) * err, GAIN_ONE),
                              -SETV_LIM, SETV_LIM);
            end else begin
                setvel = int'(trk_cmd_vel);
            end
            pterm = clip(floor_div(int'(set_vel_gain) * (setvel - vel), GAIN_ONE),
                         -PTERM_LIM, PTERM_LIM);
            dterm = clip(floor_div(int'(set_damp_gain) * (acc + int'(trk_prev_accel)),
                                   GAIN_ONE * GAIN_ONE), -DTERM_LIM, DTERM_LIM);
            adj = pterm - dterm;
        end
        trk_prev_accel = t.accel;

        diff = stick - int'(set_hold_ref);
        if (set_fast) begin
            if (iabs(diff) > STICK_BAND) begin
                trk_stick_moved = 1'b1;
                trk_last_thr = THR_W'(clip(int'(trk_last_thr) +
                                           ((stick > STICK_MID) ? -STICK_STEP : STICK_STEP),
                                           THR_MIN, THR_MAX));
            end else begin
                if (trk_stick_moved) begin
                    trk_hold_alt    = t.altitude;
                    trk_stick_moved = 1'b0;
                end
                trk_last_thr = THR_W'(clip(int'(set_base_thr) + adj, THR_MIN, THR_MAX));
            end
        end else begin
            if (iabs(diff) > STICK_BAND) begin
                trk_cmd_vel     = THR_W'(diff / 2);
                trk_vel_mode    = 1'b1;
                trk_stick_moved = 1'b1;
            end else if (trk_stick_moved) begin
                trk_hold_alt    = t.altitude;
                trk_vel_mode    = 1'b0;
                trk_stick_moved = 1'b0;
            end
            trk_last_thr = THR_W'(clip(int'(set_base_thr) + adj, THR_MIN, THR_MAX));
        end

        r.adjust = ADJ_W'(adj);
        r.motor  = trk_last_thr;
        r.vmode  = trk_vel_mode;
        return r;
    endfunction

    function automatic tick_t mk_tick(input int stick, input int alt, input int vel,
                                      input int acc, input int pitch, input int roll);
        tick_t t;
        t.stick    = THR_W'(stick);
        t.altitude = ALT_W'(alt);
        t.velocity = 12'(vel);
        t.accel    = 16'(acc);
        t.pitch    = 12'(pitch);
        t.roll     = 12'(roll);
        return t;
    endfunction

    function automatic int random_angle();
        int pick;
        pick = rnd(0, 99);
        if (pick < 80)
            return rnd(-TILT_LIM + 1, TILT_LIM - 1);
        else if (pick < 90)
            return rnd(0, 1) ? rnd(TILT_LIM - 10, TILT_LIM + 10)
                             : -rnd(TILT_LIM - 10, TILT_LIM + 10);
        return rnd(ANGLE_MIN, ANGLE_MAX);
    endfunction

    // mostly flight-like ticks: altitude random walk, stick centred, held
    // near the reference or pushed away; the rest is full-range noise
    function automatic tick_t random_tick();
        tick_t t;
        int pick, offset;
        pick = rnd(0, 99);
        if (pick < 30) begin
            t.stick = THR_W'(rnd(CENTRE_LO + 1, CENTRE_HI - 1));
        end else if (pick < 55) begin
            t.stick = THR_W'(clip(int'(set_hold_ref) + rnd(-STICK_BAND, STICK_BAND),
                                  0, STICK_MAX));
        end else if (pick < 85) begin
            offset  = rnd(STICK_BAND + 1, 500);
            t.stick = THR_W'(clip(int'(set_hold_ref) + (rnd(0, 1) ? offset : -offset),
                                  0, STICK_MAX));
        end else begin
            t.stick = THR_W'(rnd(0, STICK_MAX));
        end

        if (rnd(0, 99) < 85) begin
            alt_walk   = clip(alt_walk + rnd(-400, 400), ALT_MIN, ALT_MAX);
            t.altitude = ALT_W'(alt_walk);
        end else begin
            t.altitude = ALT_W'($urandom);
        end

        t.velocity = (rnd(0, 99) < 70) ? 12'(rnd(-400, 400)) : 12'($urandom);
        t.accel    = (rnd(0, 99) < 60) ? 16'(rnd(-3000, 3000)) : 16'($urandom);
        t.pitch    = 12'(random_angle());
        t.roll     = 12'(random_angle());
        return t;
    endfunction

    task automatic send_item(input tick_t t);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid              <= 1'b1;
        s_stick_throttle     <= t.stick;
        s_estimated_altitude <= t.altitude;
        s_vertical_velocity  <= t.velocity;
        s_vertical_accel     <= t.accel;
        s_pitch_angle        <= t.pitch;
        s_roll_angle         <= t.roll;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_cmds.push_back(predict_throttle(t));
        ticks_sent++;
    endtask

    task automatic wait_for_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_FAST_MODE: set_fast      = data[0];
            REG_STICK_REF: set_hold_ref  = data[THR_W-1:0];
            REG_BASE_THR:  set_base_thr  = data[THR_W-1:0];
            REG_ALT_GAIN:  set_alt_gain  = data[GAIN_W-1:0];
            REG_VEL_GAIN:  set_vel_gain  = data[GAIN_W-1:0];
            REG_DAMP_GAIN: set_damp_gain = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
        wait_for_idle();
        write_reg(idx, data);
        end_writes();
    endtask

    // unused upper data bits carry noise; the block must drop them
    task automatic apply_config(input cfg_t c);
        logic [CFG_DAT_W-1:0] noise;
        noise = CFG_DAT_W'($urandom);
        wait_for_idle();
        write_reg(REG_FAST_MODE, {noise[CFG_DAT_W-1:1], c.fast});
        write_reg(REG_STICK_REF, {noise[CFG_DAT_W-1:THR_W], c.hold_ref});
        write_reg(REG_BASE_THR,  {noise[CFG_DAT_W-1:THR_W], c.base});
        write_reg(REG_ALT_GAIN,  c.alt_gain);
        write_reg(REG_VEL_GAIN,  c.vel_gain);
        write_reg(REG_DAMP_GAIN, c.damp_gain);
        end_writes();
        settings_applied++;
    endtask

    function automatic cfg_t phase_config(input int phase);
        cfg_t c;
        case (phase)
            0: c = '{1'b0, THR_W'(HOLD_REF_RST), THR_W'(BASE_RST),
                     GAIN_W'(GAIN_ONE), GAIN_W'(GAIN_ONE), '0};
            1: c = '{1'b1, THR_W'(HOLD_REF_RST), THR_W'(1300),
                     GAIN_W'(512), GAIN_W'(384), GAIN_W'(200)};
            2: c = '{1'b0, THR_W'(STICK_MAX), THR_W'(STICK_MAX),
                     GAIN_W'(GAIN_MAX), GAIN_W'(GAIN_MAX), GAIN_W'(GAIN_MAX)};
            3: c = '{1'b1, '0, '0, '0, '0, '0};
            default: begin
                c.fast      = phase[0];
                c.hold_ref  = THR_W'(rnd(1350, 1650));
                c.base      = THR_W'(rnd(900, STICK_MAX));
                c.alt_gain  = GAIN_W'(rnd(0, GAIN_MAX));
                c.vel_gain  = GAIN_W'(rnd(0, GAIN_MAX));
                c.damp_gain = GAIN_W'(rnd(0, GAIN_MAX));
            end
        endcase
        return c;
    endfunction

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 59; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            IDLE_BOTH:     begin send_idle_pct = 23; recv_stall_pct = 23; end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_defaults();
        send_item(mk_tick(1500, 0, 0, 0, 0, 0));                // centred, capture
        send_item(mk_tick(CENTRE_LO, 5, 0, 0, 0, 0));           // inside deadband
        send_item(mk_tick(CENTRE_HI, -700, 0, 0, 0, 0));        // error clamp high
        send_item(mk_tick(CENTRE_HI, 700, VEL_MAX, ACC_MAX, 0, 0));
    endtask

    task automatic test_register_map();
        set_reg(REG_UNUSED_LO, CFG_DAT_W'($urandom));
        set_reg(REG_UNUSED_HI, CFG_DAT_W'($urandom));
        set_reg(REG_DAMP_GAIN, CFG_DAT_W'(GAIN_MAX));
        // damping saturates high, altitude at its extremes
        send_item(mk_tick(1500, ALT_MAX, VEL_MIN, ACC_MAX, 0, 0));
        send_item(mk_tick(1500, ALT_MIN, 0, ACC_MIN, TILT_LIM - 1, -(TILT_LIM - 1)));
    endtask

    task automatic test_tilt_guard();
        send_item(mk_tick(1500, 0, 0, ACC_MIN, TILT_LIM, 0));
        send_item(mk_tick(1500, 0, 0, 0, 0, -TILT_LIM));
        send_item(mk_tick(1500, 0, 0, 0, ANGLE_MIN, ANGLE_MAX));
    endtask

    task automatic test_slow_stick();
        send_item(mk_tick(STICK_MAX, 0, 100, 0, 0, 0));         // climb commanded
        send_item(mk_tick(STICK_MAX, 0, 100, 0, 0, 0));
        send_item(mk_tick(0, 30, VEL_MIN, 0, 0, 0));            // descend commanded
        send_item(mk_tick(1500, 60, 0, 0, 0, 0));               // back to centre
        send_item(mk_tick(1600, 90, 0, 0, 0, 0));
    endtask

    // velocity mode from the slow-mode move survives the switch
    task automatic test_fast_stick();
        set_reg(REG_FAST_MODE, CFG_DAT_W'(1));
        send_item(mk_tick(1500, 120, 0, 0, 0, 0));
        send_item(mk_tick(1600, 150, 0, 0, 0, 0));
        send_item(mk_tick(0, 150, 0, 0, 0, 0));
        send_item(mk_tick(STICK_MID, 150, 0, 0, 0, 0));
        send_item(mk_tick(STICK_MID + 1, 150, 0, 0, 0, 0));
    endtask

    task automatic test_throttle_saturation();
        set_reg(REG_BASE_THR, CFG_DAT_W'(STICK_MAX));
        send_item(mk_tick(1500, 0, 0, 0, 0, 0));
        send_item(mk_tick(500, 0, 0, 0, 0, 0));
        set_reg(REG_BASE_THR, '0);
        send_item(mk_tick(1500, 0, 0, 0, 0, 0));
        send_item(mk_tick(STICK_MAX, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_flight();
        int phase, n;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_idling(idle_mode_t'(phase % 4));
            apply_config(phase_config(phase));
            alt_walk = rnd(-2000, 2000);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2)
                    wait_for_idle();
                send_item(random_tick());
            end
        end
    endtask

    // ------------------------------------------------------------- checking

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_cmds.size() == 0) begin
                $error("throttle command transfer with nothing expected");
                errors++;
            end else begin
                thr_cmd_t exp_cmd;
                exp_cmd = expected_cmds.pop_front();
                if (m_throttle_adjustment !== exp_cmd.adjust) begin
                    $error("throttle_adjustment: expected %0d, got %0d",
                           exp_cmd.adjust, m_throttle_adjustment);
                    errors++;
                end
                if (m_motor_throttle !== exp_cmd.motor) begin
                    $error("motor_throttle: expected %0d, got %0d",
                           exp_cmd.motor, m_motor_throttle);
                    errors++;
                end
                if (m_velocity_mode !== exp_cmd.vmode) begin
                    $error("velocity_mode: expected %0d, got %0d",
                           exp_cmd.vmode, m_velocity_mode);
                    errors++;
                end
                cmds_checked++;
            end
        end
    end

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn              = 1'b0;
        cfg_valid            = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        s_valid              = 1'b0;
        s_stick_throttle     = '0;
        s_estimated_altitude = '0;
        s_vertical_velocity  = '0;
        s_vertical_accel     = '0;
        s_pitch_angle        = '0;
        s_roll_angle         = '0;
        reset_tracker();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_register_map();
        test_tilt_guard();
        test_slow_stick();
        test_fast_stick();
        test_throttle_saturation();
        test_random_flight();

        wait_for_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_cmds.size() != 0) begin
            $error("%0d throttle commands never arrived", expected_cmds.size());
            errors++;
        end

        $display("Sent %0d control ticks under %0d register settings plus directed writes,",
                 ticks_sent, settings_applied);
        $display("checked %0d throttle commands with sender gaps and receiver stalls.",
                 cmds_checked);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
